// ===== rtl/scope_frame_receiver_with_peak_stats_macros.svh =====
// assertion macros for the scope frame receiver
// used by the top level only, clock and reset are taken by name
`ifndef SCOPE_FRAME_RECEIVER_WITH_PEAK_STATS_MACROS_SVH
`define SCOPE_FRAME_RECEIVER_WITH_PEAK_STATS_MACROS_SVH

// same-cycle implication, masked while in reset
`define SFR_ASSERT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sfr assertion failed");

// next-cycle implication, masked while in reset
`define SFR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sfr assertion failed");

// next-cycle implication that also holds across reset
`define SFR_ASSERT_RESET(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("sfr reset assertion failed");

`endif

// ===== rtl/sfr_pkg.sv =====
// shared types and constants for the scope frame receiver
// no dependencies
package sfr_pkg;

   localparam int MAX_PAIRS   = 4096;
   localparam int PAIR_W      = $clog2(MAX_PAIRS);
   localparam int NEEDED_W    = 13;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   localparam logic [15:0] MIN_START = 16'd4095;

   // configuration register indexes
   localparam logic [2:0] CSR_SYNC_FIRST    = 3'd0;
   localparam logic [2:0] CSR_SYNC_SECOND   = 3'd1;
   localparam logic [2:0] CSR_FRAME_PAIRS   = 3'd2;
   localparam logic [2:0] CSR_TIMEOUT_TICKS = 3'd3;
   localparam logic [2:0] CSR_MIN_SWING     = 3'd4;

   // configuration reset values
   localparam logic [7:0]  RST_SYNC_FIRST    = 8'hFF;
   localparam logic [7:0]  RST_SYNC_SECOND   = 8'hFE;
   localparam logic [12:0] RST_FRAME_PAIRS   = 13'd2000;
   localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd1000;
   localparam logic [15:0] RST_MIN_SWING     = 16'd250;

   typedef struct packed {
      logic [7:0]  sync_first;
      logic [7:0]  sync_second;
      logic [12:0] frame_pairs;
      logic [15:0] timeout_ticks;
      logic [15:0] min_swing;
   } cfg_type;

   typedef enum logic [1:0] {
      EV_START,
      EV_FREQ,
      EV_SAMPLE,
      EV_LAST
   } ev_kind_type;

   // sel: frequency word index or channel index
   typedef struct packed {
      ev_kind_type kind;
      logic        sel;
      logic [31:0] data;
   } ev_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              push;
      logic              pop;
      logic              full;
   } queue_stat_type;

endpackage

// ===== rtl/sfr_front.sv =====
// frame parser: sync hunt, frequency word assembly, sample byte pairing, timeout
// depends on sfr_pkg; feeds events into sfr_queue
module sfr_front (
   input  logic            clock,
   input  logic            reset,
   input  sfr_pkg::cfg_type cfg,
   input  logic            in_valid,
   input  logic            in_op,
   input  logic [7:0]      in_byte,
   input  logic            queue_full,
   output logic            in_ready,
   output logic            ev_push,
   output sfr_pkg::ev_type ev
);
   import sfr_pkg::*;

   typedef enum logic [1:0] {
      PH_HUNT1,
      PH_HUNT2,
      PH_FREQ,
      PH_SAMP
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [2:0]        slot_ff, slot_in;
   logic [PAIR_W-1:0] pairs_ff, pairs_in;
   logic [23:0]       held_ff, held_in;
   logic [15:0]       idle_ff, idle_in;

   logic                accept;
   logic [NEEDED_W-1:0] needed;
   logic [NEEDED_W-1:0] pair_next;
   logic [15:0]         idle_sat;
   logic [1:0]          pos;
   logic [15:0]         sample;

   assign in_ready = !queue_full;
   assign accept   = in_valid && in_ready;
   assign pos      = slot_ff[1:0];
   assign sample   = {in_byte, held_ff[7:0]};
   assign idle_sat = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;
   assign pair_next = NEEDED_W'({1'b0, pairs_ff}) + NEEDED_W'(1);

   always_comb begin
      if (cfg.frame_pairs == '0) begin
         needed = NEEDED_W'(1);
      end else if (cfg.frame_pairs > NEEDED_W'(MAX_PAIRS)) begin
         needed = NEEDED_W'(MAX_PAIRS);
      end else begin
         needed = cfg.frame_pairs;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      slot_in  = slot_ff;
      pairs_in = pairs_ff;
      held_in  = held_ff;
      idle_in  = idle_ff;
      ev_push  = 1'b0;
      ev.kind  = EV_START;
      ev.sel   = 1'b0;
      ev.data  = '0;
      if (accept) begin
         if (in_op) begin
            // timer tick
            if (phase_ff != PH_HUNT1) begin
               idle_in = idle_sat;
               if (idle_sat > cfg.timeout_ticks) begin
                  phase_in = PH_HUNT1;
                  slot_in  = '0;
                  pairs_in = '0;
                  held_in  = '0;
                  idle_in  = '0;
               end
            end
         end else begin
            idle_in = '0;
            case (phase_ff)
               PH_HUNT1: begin
                  if (in_byte == cfg.sync_first) phase_in = PH_HUNT2;
               end
               PH_HUNT2: begin
                  if (in_byte == cfg.sync_second) begin
                     phase_in = PH_FREQ;
                     slot_in  = '0;
                     pairs_in = '0;
                     held_in  = '0;
                     ev_push  = 1'b1;
                     ev.kind  = EV_START;
                  end else begin
                     phase_in = PH_HUNT1;
                  end
               end
               PH_FREQ: begin
                  if (pos == 2'd3) begin
                     ev_push = 1'b1;
                     ev.kind = EV_FREQ;
                     ev.sel  = slot_ff[2];
                     ev.data = {in_byte, held_ff};
                     held_in = '0;
                  end else begin
                     held_in = held_ff | ({16'd0, in_byte} << {pos, 3'b000});
                  end
                  if (slot_ff == 3'd7) begin
                     phase_in = PH_SAMP;
                     slot_in  = '0;
                     pairs_in = '0;
                  end else begin
                     slot_in = slot_ff + 3'd1;
                  end
               end
               PH_SAMP: begin
                  if (!pos[0]) begin
                     held_in = {16'd0, in_byte};
                     slot_in = {1'b0, pos} + 3'd1;
                  end else begin
                     held_in = '0;
                     ev_push = 1'b1;
                     ev.data = {16'd0, sample};
                     if (pos == 2'd1) begin
                        ev.kind = EV_SAMPLE;
                        ev.sel  = 1'b0;
                        slot_in = 3'd2;
                     end else begin
                        ev.sel  = 1'b1;
                        slot_in = '0;
                        if (pair_next >= needed) begin
                           ev.kind  = EV_LAST;
                           phase_in = PH_HUNT1;
                           pairs_in = '0;
                        end else begin
                           ev.kind  = EV_SAMPLE;
                           pairs_in = pairs_ff + PAIR_W'(1);
                        end
                     end
                  end
               end
               default: phase_in = PH_HUNT1;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT1;
         slot_ff  <= '0;
         pairs_ff <= '0;
         held_ff  <= '0;
         idle_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         slot_ff  <= slot_in;
         pairs_ff <= pairs_in;
         held_ff  <= held_in;
         idle_ff  <= idle_in;
      end
   end

endmodule

// ===== rtl/sfr_queue.sv =====
// short event queue between the parser and the statistics stage
// depends on sfr_pkg
module sfr_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  sfr_pkg::ev_type        push_ev,
   input  logic                   pop,
   output logic                   empty,
   output logic                   full,
   output sfr_pkg::ev_type        head,
   output sfr_pkg::queue_stat_type stat
);
   import sfr_pkg::*;

   ev_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   assign stat.count = count_ff;
   assign stat.push  = do_push;
   assign stat.pop   = do_pop;
   assign stat.full  = full;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + QCNT_W'(1);
      if (!do_push && do_pop) count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_ev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/sfr_back.sv =====
// statistics stage: min/max tracking, frame snapshot, result calculation and output register
// depends on sfr_pkg; drains sfr_queue
module sfr_back (
   input  logic            clock,
   input  logic            reset,
   input  logic [15:0]     min_swing,
   input  logic            ev_avail,
   input  sfr_pkg::ev_type ev,
   output logic            ev_pop,
   output logic            out_valid,
   input  logic            out_ready,
   output logic [143:0]    out_data
);
   import sfr_pkg::*;

   logic [31:0] freq_ff [2];
   logic [15:0] max_ff  [2];
   logic [15:0] min_ff  [2];
   logic [31:0] freq_in [2];
   logic [15:0] max_in  [2];
   logic [15:0] min_in  [2];

   // frame snapshot taken on the last sample
   logic        snap_valid_ff, snap_valid_in;
   logic [31:0] snap_freq_ff [2];
   logic [15:0] snap_max_ff  [2];
   logic [15:0] snap_min_ff  [2];

   logic         out_valid_ff, out_valid_in;
   logic [143:0] out_data_ff;

   logic        out_free, snap_free, snap_move, pop_last;
   logic [15:0] swing [2];
   logic [16:0] sum   [2];
   logic [15:0] mid   [2];
   logic [7:0]  level [2];

   assign out_free  = !out_valid_ff || out_ready;
   assign snap_move = snap_valid_ff && out_free;
   assign snap_free = !snap_valid_ff || out_free;
   assign ev_pop    = ev_avail && (ev.kind != EV_LAST || snap_free);
   assign pop_last  = ev_pop && (ev.kind == EV_LAST);

   always_comb begin
      for (int ch = 0; ch < 2; ch++) begin
         freq_in[ch] = freq_ff[ch];
         max_in[ch]  = max_ff[ch];
         min_in[ch]  = min_ff[ch];
      end
      if (ev_pop) begin
         case (ev.kind)
            EV_START: begin
               for (int ch = 0; ch < 2; ch++) begin
                  max_in[ch] = '0;
                  min_in[ch] = MIN_START;
               end
            end
            EV_FREQ: begin
               for (int ch = 0; ch < 2; ch++) begin
                  if (ev.sel == ch[0]) freq_in[ch] = ev.data;
               end
            end
            EV_SAMPLE, EV_LAST: begin
               for (int ch = 0; ch < 2; ch++) begin
                  if (ev.sel == ch[0]) begin
                     if (ev.data[15:0] > max_ff[ch]) max_in[ch] = ev.data[15:0];
                     if (ev.data[15:0] < min_ff[ch]) min_in[ch] = ev.data[15:0];
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      snap_valid_in = snap_valid_ff;
      if (snap_move) snap_valid_in = 1'b0;
      if (pop_last) snap_valid_in = 1'b1;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && out_ready) out_valid_in = 1'b0;
      if (snap_move) out_valid_in = 1'b1;
   end

   always_comb begin
      for (int ch = 0; ch < 2; ch++) begin
         swing[ch] = (snap_max_ff[ch] >= snap_min_ff[ch]) ?
                     snap_max_ff[ch] - snap_min_ff[ch] : 16'd0;
         sum[ch]   = {1'b0, snap_max_ff[ch]} + {1'b0, snap_min_ff[ch]};
         mid[ch]   = sum[ch][16:1];
         if (swing[ch] > min_swing) begin
            // midpoint over sixteen, saturated to a byte
            level[ch] = (mid[ch][15:12] != 4'd0) ? 8'hFF : mid[ch][11:4];
         end else begin
            level[ch] = 8'hFF;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int ch = 0; ch < 2; ch++) begin
            freq_ff[ch] <= '0;
            max_ff[ch]  <= '0;
            min_ff[ch]  <= MIN_START;
         end
         snap_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         for (int ch = 0; ch < 2; ch++) begin
            freq_ff[ch] <= freq_in[ch];
            max_ff[ch]  <= max_in[ch];
            min_ff[ch]  <= min_in[ch];
         end
         snap_valid_ff <= snap_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_last) begin
         for (int ch = 0; ch < 2; ch++) begin
            snap_freq_ff[ch] <= freq_in[ch];
            snap_max_ff[ch]  <= max_in[ch];
            snap_min_ff[ch]  <= min_in[ch];
         end
      end
      if (snap_move) begin
         out_data_ff <= {level[1], level[0], mid[1], swing[1], mid[0], swing[0],
                         snap_freq_ff[1], snap_freq_ff[0]};
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

// ===== rtl/scope_frame_receiver_with_peak_stats.sv =====
// scope frame receiver: one byte or tick accepted per clock unless the event queue is full,
// a rate set by the single-byte parser step; parsed in front, stats at the back; a frame's
// result passes the queue, snapshot and output register, later behind queued events or stalls
// reset: synchronous, clears parser state, queue, statistics and loads register defaults
// depends on sfr_pkg, sfr_front, sfr_queue, sfr_back and the assertion macro header
`include "scope_frame_receiver_with_peak_stats_macros.svh"

module scope_frame_receiver_with_peak_stats (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic         req_tuser,   // op
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // freq_one, freq_two, swing_one, middle_one, swing_two, middle_two, level_one, level_two
   output logic [143:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_wdata
);
   import sfr_pkg::*;

   cfg_type        cfg_ff;
   logic           ev_push, ev_pop, q_empty, q_full;
   ev_type         ev_new, ev_head;
   queue_stat_type q_stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first    <= RST_SYNC_FIRST;
         cfg_ff.sync_second   <= RST_SYNC_SECOND;
         cfg_ff.frame_pairs   <= RST_FRAME_PAIRS;
         cfg_ff.timeout_ticks <= RST_TIMEOUT_TICKS;
         cfg_ff.min_swing     <= RST_MIN_SWING;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SYNC_FIRST:    cfg_ff.sync_first    <= csr_wdata[7:0];
            CSR_SYNC_SECOND:   cfg_ff.sync_second   <= csr_wdata[7:0];
            CSR_FRAME_PAIRS:   cfg_ff.frame_pairs   <= csr_wdata[12:0];
            CSR_TIMEOUT_TICKS: cfg_ff.timeout_ticks <= csr_wdata;
            CSR_MIN_SWING:     cfg_ff.min_swing     <= csr_wdata;
            default: ;
         endcase
      end
   end

   sfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_op      (req_tuser),
      .in_byte    (req_tdata),
      .queue_full (q_full),
      .in_ready   (req_tready),
      .ev_push    (ev_push),
      .ev         (ev_new)
   );

   sfr_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (ev_push),
      .push_ev (ev_new),
      .pop     (ev_pop),
      .empty   (q_empty),
      .full    (q_full),
      .head    (ev_head),
      .stat    (q_stat)
   );

   sfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .min_swing (cfg_ff.min_swing),
      .ev_avail  (!q_empty),
      .ev        (ev_head),
      .ev_pop    (ev_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

   `SFR_ASSERT_RESET(a_reset_clean, reset, !rsp_tvalid && q_stat.count == '0)
   `SFR_ASSERT_NEXT(a_count_up, q_stat.push && !q_stat.pop, (q_stat.count - $past(q_stat.count)) == QCNT_W'(1))
   `SFR_ASSERT_NEXT(a_count_down, q_stat.pop && !q_stat.push, ($past(q_stat.count) - q_stat.count) == QCNT_W'(1))
   `SFR_ASSERT(a_no_push_when_full, req_tvalid && req_tready, !q_stat.full)

endmodule
